[design/gtc_pkg.sv]
// Shared types and constants of the greedy tour crossover block.
// Used by the controller, the tour scanners, the datapath core and the top level.
package gtc_pkg;

   localparam int NUM_CITIES_DEF = 36;
   localparam int COORD_BITS_DEF = 16;
   localparam int CITY_W         = 6;
   localparam int POS_W          = 6;
   localparam int IN_COORD_W     = 16;

   localparam logic [1:0] OP_LOAD_COORD = 2'd0;
   localparam logic [1:0] OP_LOAD_GENES = 2'd1;
   localparam logic [1:0] OP_RUN        = 2'd2;

   typedef struct packed {
      logic [1:0]                   opcode;
      logic [POS_W-1:0]             position;
      logic signed [IN_COORD_W-1:0] coord_x;
      logic signed [IN_COORD_W-1:0] coord_y;
      logic [CITY_W-1:0]            first_parent_city;
      logic [CITY_W-1:0]            second_parent_city;
   } req_type;

   typedef struct packed {
      logic [CITY_W-1:0] offspring_city;
      logic [CITY_W-1:0] complement_city;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic coord_we;
      logic gene_we;
   } load_type;

   typedef struct packed {
      logic head;
      logic scan;
   } scan_cmd_type;

   typedef struct packed {
      logic              done;
      logic              found;
      logic [CITY_W-1:0] city;
   } scan_sts_type;

   typedef enum logic [1:0] {
      RD_CUR,
      RD_C1,
      RD_C2
   } rd_sel_type;

   typedef enum logic [2:0] {
      UPD_NONE,
      UPD_HEAD,
      UPD_C1,
      UPD_C2,
      UPD_NEAR,
      UPD_KEEP
   } upd_type;

   typedef struct packed {
      logic       clear;
      rd_sel_type rd_sel;
      logic       lat_cur;
      logic       diff;
      logic       square;
      logic       sum1;
      logic       sum2;
      upd_type    upd;
      logic       last;
   } core_cmd_type;

endpackage

[design/gtc_scan.sv]
// Tour memory of one parent with its search engine: reads the head of the
// tour, or finds the current city in the tour, then walks forward cyclically
// to the first unvisited city. Depends on gtc_pkg.
module gtc_scan #(
   parameter int NUM_CITIES = gtc_pkg::NUM_CITIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [gtc_pkg::POS_W-1:0]   wr_pos,
   input  logic [gtc_pkg::CITY_W-1:0]  wr_city,
   input  gtc_pkg::scan_cmd_type       cmd,
   input  logic [gtc_pkg::CITY_W-1:0]  cur_city,
   input  logic [NUM_CITIES-1:0]       visited,
   output gtc_pkg::scan_sts_type       sts
);
   import gtc_pkg::*;

   localparam int IW = $clog2(NUM_CITIES);
   localparam int CW = $clog2(NUM_CITIES + 1);
   localparam logic [CITY_W:0] N_EXT    = (CITY_W + 1)'(NUM_CITIES);
   localparam logic [IW-1:0]   LAST_POS = IW'(NUM_CITIES - 1);
   localparam logic [CW-1:0]   N_CNT    = CW'(NUM_CITIES);
   localparam logic [CW-1:0]   LAST_CNT = CW'(NUM_CITIES - 1);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEAD,
      PH_FIND,
      PH_SEEK
   } phase_type;

   logic [CITY_W-1:0] tour_mem [NUM_CITIES];
   logic [CITY_W-1:0] rd_gene_ff;

   phase_type         phase_ff, phase_in;
   logic [IW-1:0]     iss_ptr_ff, iss_ptr_in;
   logic [CW-1:0]     iss_cnt_ff, iss_cnt_in;
   logic [CW-1:0]     chk_cnt_ff, chk_cnt_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IW-1:0]     rd_pos_ff, rd_pos_in;
   logic              done_ff, done_in;
   logic              found_ff, found_in;
   logic [CITY_W-1:0] city_ff, city_in;

   logic [IW-1:0]     rd_addr;
   logic              hit;
   logic              unvisited;
   logic [IW-1:0]     start_pos;
   logic [IW-1:0]     ptr_next;
   logic [IW-1:0]     start_next;

   function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
      logic [IW-1:0] r;
      r = (p == LAST_POS) ? '0 : p + 1'b1;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en && ({1'b0, wr_pos} < N_EXT)) begin
         tour_mem[wr_pos[IW-1:0]] <= wr_city;
      end
      rd_gene_ff <= tour_mem[rd_addr];
   end

   assign hit        = (rd_gene_ff == cur_city);
   assign unvisited  = !({1'b0, rd_gene_ff} < N_EXT) || !visited[rd_gene_ff[IW-1:0]];
   assign start_pos  = hit ? wrap_inc(rd_pos_ff) : '0;
   assign ptr_next   = wrap_inc(iss_ptr_ff);
   assign start_next = wrap_inc(start_pos);

   always_comb begin
      phase_in   = phase_ff;
      iss_ptr_in = iss_ptr_ff;
      iss_cnt_in = iss_cnt_ff;
      chk_cnt_in = chk_cnt_ff;
      done_in    = 1'b0;
      found_in   = found_ff;
      city_in    = city_ff;
      rd_addr    = iss_ptr_ff;
      rd_vld_in  = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (cmd.head) begin
               rd_addr   = '0;
               rd_vld_in = 1'b1;
               phase_in  = PH_HEAD;
            end else if (cmd.scan) begin
               iss_ptr_in = '0;
               iss_cnt_in = '0;
               phase_in   = PH_FIND;
            end
         end
         PH_HEAD: begin
            if (rd_vld_ff) begin
               done_in  = 1'b1;
               found_in = 1'b1;
               city_in  = rd_gene_ff;
               phase_in = PH_IDLE;
            end
         end
         PH_FIND: begin
            // The search issues positions in order, so the last position
            // returning without a match means the city is absent.
            if (rd_vld_ff && (hit || (rd_pos_ff == LAST_POS))) begin
               rd_addr    = start_pos;
               rd_vld_in  = 1'b1;
               iss_ptr_in = start_next;
               iss_cnt_in = CW'(1);
               chk_cnt_in = '0;
               phase_in   = PH_SEEK;
            end else if (iss_cnt_ff < N_CNT) begin
               rd_vld_in  = 1'b1;
               iss_ptr_in = ptr_next;
               iss_cnt_in = iss_cnt_ff + 1'b1;
            end
         end
         PH_SEEK: begin
            if (rd_vld_ff && unvisited) begin
               done_in  = 1'b1;
               found_in = 1'b1;
               city_in  = rd_gene_ff;
               phase_in = PH_IDLE;
            end else if (rd_vld_ff && (chk_cnt_ff == LAST_CNT)) begin
               done_in  = 1'b1;
               found_in = 1'b0;
               phase_in = PH_IDLE;
            end else begin
               if (rd_vld_ff) begin
                  chk_cnt_in = chk_cnt_ff + 1'b1;
               end
               if (iss_cnt_ff < N_CNT) begin
                  rd_vld_in  = 1'b1;
                  iss_ptr_in = ptr_next;
                  iss_cnt_in = iss_cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   assign rd_pos_in = rd_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         iss_ptr_ff <= '0;
         iss_cnt_ff <= '0;
         chk_cnt_ff <= '0;
         rd_vld_ff  <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         iss_ptr_ff <= iss_ptr_in;
         iss_cnt_ff <= iss_cnt_in;
         chk_cnt_ff <= chk_cnt_in;
         rd_vld_ff  <= rd_vld_in;
         done_ff    <= done_in;
      end
      rd_pos_ff <= rd_pos_in;
      found_ff  <= found_in;
      city_ff   <= city_in;
   end

   assign sts.done  = done_ff;
   assign sts.found = found_ff;
   assign sts.city  = city_ff;

endmodule

[design/gtc_core.sv]
// Datapath core: coordinate memory, visited map, current city, squared
// distance pipeline and the result register. Depends on gtc_pkg.
module gtc_core #(
   parameter int NUM_CITIES = gtc_pkg::NUM_CITIES_DEF,
   parameter int COORD_BITS = gtc_pkg::COORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        coord_we,
   input  gtc_pkg::req_type            req,
   input  gtc_pkg::core_cmd_type       cmd,
   input  gtc_pkg::scan_sts_type       sts1,
   input  gtc_pkg::scan_sts_type       sts2,
   output logic [gtc_pkg::CITY_W-1:0]  cur_city,
   output logic [NUM_CITIES-1:0]       visited,
   output gtc_pkg::rsp_type            rsp,
   output logic                        rsp_strobe
);
   import gtc_pkg::*;

   localparam int IW   = $clog2(NUM_CITIES);
   localparam int CB   = COORD_BITS;
   localparam int SQW  = 2 * CB;
   localparam int SUMW = SQW + 1;
   localparam logic [CITY_W:0]   N_EXT    = (CITY_W + 1)'(NUM_CITIES);
   localparam logic [CITY_W-1:0] TOP_CITY = CITY_W'(NUM_CITIES - 1);

   logic [2*CB-1:0]    xy_mem [NUM_CITIES];
   logic [2*CB-1:0]    rd_xy_ff;
   logic               rd_oor_ff;
   logic [CITY_W-1:0]  rd_city;
   logic               coord_ok;

   logic [CB-1:0]      pt_x, pt_y;
   logic [CB-1:0]      cur_x_ff, cur_y_ff;
   logic [CB:0]        dx_raw, dy_raw;
   logic [CB-1:0]      dx_in, dy_in;
   logic [CB-1:0]      dx_ff, dy_ff;
   logic [SQW-1:0]     sqx_ff, sqy_ff;
   logic [SUMW-1:0]    sum_in, d1_ff, d2_ff;

   logic [CITY_W-1:0]  cur_ff, next_city;
   logic [NUM_CITIES-1:0] visited_ff;
   rsp_type            rsp_ff;
   logic               strobe_ff;
   logic               mark;

   assign coord_ok = coord_we && ({1'b0, req.position} < N_EXT);

   always_comb begin
      case (cmd.rd_sel)
         RD_CUR:  rd_city = cur_ff;
         RD_C1:   rd_city = sts1.city;
         RD_C2:   rd_city = sts2.city;
         default: rd_city = cur_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (coord_ok) begin
         xy_mem[req.position[IW-1:0]] <= {CB'(req.coord_x), CB'(req.coord_y)};
      end
      rd_xy_ff  <= xy_mem[rd_city[IW-1:0]];
      rd_oor_ff <= !({1'b0, rd_city} < N_EXT);
   end

   // A city outside the table sits at the origin.
   assign pt_x = rd_oor_ff ? '0 : rd_xy_ff[2*CB-1:CB];
   assign pt_y = rd_oor_ff ? '0 : rd_xy_ff[CB-1:0];

   assign dx_raw = {pt_x[CB-1], pt_x} - {cur_x_ff[CB-1], cur_x_ff};
   assign dy_raw = {pt_y[CB-1], pt_y} - {cur_y_ff[CB-1], cur_y_ff};
   assign dx_in  = dx_raw[CB] ? CB'(-dx_raw) : dx_raw[CB-1:0];
   assign dy_in  = dy_raw[CB] ? CB'(-dy_raw) : dy_raw[CB-1:0];
   assign sum_in = SUMW'(sqx_ff) + SUMW'(sqy_ff);

   always_ff @(posedge clock) begin
      if (cmd.lat_cur) begin
         cur_x_ff <= pt_x;
         cur_y_ff <= pt_y;
      end
      if (cmd.diff) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (cmd.square) begin
         sqx_ff <= SQW'(dx_ff) * SQW'(dx_ff);
         sqy_ff <= SQW'(dy_ff) * SQW'(dy_ff);
      end
      if (cmd.sum1) begin
         d1_ff <= sum_in;
      end
      if (cmd.sum2) begin
         d2_ff <= sum_in;
      end
   end

   // A tie in distance goes to parent two.
   always_comb begin
      case (cmd.upd)
         UPD_HEAD: next_city = sts1.city;
         UPD_C1:   next_city = sts1.city;
         UPD_C2:   next_city = sts2.city;
         UPD_NEAR: next_city = (d1_ff < d2_ff) ? sts1.city : sts2.city;
         UPD_KEEP: next_city = cur_ff;
         default:  next_city = cur_ff;
      endcase
   end

   assign mark = (cmd.upd != UPD_NONE) && (cmd.upd != UPD_KEEP)
                 && ({1'b0, next_city} < N_EXT);

   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff <= '0;
         cur_ff     <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         strobe_ff <= (cmd.upd != UPD_NONE);
         if (cmd.clear) begin
            visited_ff <= '0;
         end else if (mark) begin
            visited_ff[next_city[IW-1:0]] <= 1'b1;
         end
         if (cmd.upd != UPD_NONE) begin
            cur_ff <= next_city;
         end
      end
      if (cmd.upd != UPD_NONE) begin
         rsp_ff.offspring_city  <= next_city;
         rsp_ff.complement_city <= TOP_CITY - next_city;
         rsp_ff.last            <= cmd.last;
      end
   end

   assign cur_city   = cur_ff;
   assign visited    = visited_ff;
   assign rsp        = rsp_ff;
   assign rsp_strobe = strobe_ff;

endmodule

[design/gtc_ctrl.sv]
// Controller of the greedy tour crossover: decodes requests and sequences
// head read, tour scans, distance pipeline and updates. Depends on gtc_pkg.
module gtc_ctrl #(
   parameter int NUM_CITIES = gtc_pkg::NUM_CITIES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             opcode,
   input  gtc_pkg::scan_sts_type  sts1,
   input  gtc_pkg::scan_sts_type  sts2,
   output logic                   busy,
   output gtc_pkg::load_type      load,
   output gtc_pkg::scan_cmd_type  scan1_cmd,
   output gtc_pkg::scan_cmd_type  scan2_cmd,
   output gtc_pkg::core_cmd_type  core_cmd
);
   import gtc_pkg::*;

   localparam int IW = $clog2(NUM_CITIES);
   localparam logic [IW-1:0] LAST_STEP = IW'(NUM_CITIES - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HEAD,
      ST_SCAN_GO,
      ST_SCAN_WAIT,
      ST_D1,
      ST_D2,
      ST_D3,
      ST_D4,
      ST_D5,
      ST_D6
   } state_type;

   state_type     state_ff;
   logic [IW-1:0] step_ff;
   logic          got1_ff, got2_ff;
   scan_cmd_type  scan1_ff, scan2_ff;
   core_cmd_type  core_ff;

   logic          take;
   logic          both_done;
   logic          last_step;

   assign busy          = (state_ff != ST_IDLE);
   assign take          = start && !busy;
   assign load.coord_we = take && (opcode == OP_LOAD_COORD);
   assign load.gene_we  = take && (opcode == OP_LOAD_GENES);
   assign both_done     = (got1_ff || sts1.done) && (got2_ff || sts2.done);
   assign last_step     = (step_ff == LAST_STEP);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         got1_ff  <= 1'b0;
         got2_ff  <= 1'b0;
         scan1_ff <= '0;
         scan2_ff <= '0;
         core_ff  <= '0;
      end else begin
         scan1_ff <= '0;
         scan2_ff <= '0;
         core_ff  <= '0;
         case (state_ff)
            ST_IDLE: begin
               if (take && (opcode == OP_RUN)) begin
                  core_ff.clear <= 1'b1;
                  scan1_ff.head <= 1'b1;
                  state_ff      <= ST_HEAD;
               end
            end
            ST_HEAD: begin
               if (sts1.done) begin
                  core_ff.upd  <= UPD_HEAD;
                  core_ff.last <= 1'b0;
                  step_ff      <= IW'(1);
                  state_ff     <= ST_SCAN_GO;
               end
            end
            ST_SCAN_GO: begin
               scan1_ff.scan <= 1'b1;
               scan2_ff.scan <= 1'b1;
               got1_ff       <= 1'b0;
               got2_ff       <= 1'b0;
               state_ff      <= ST_SCAN_WAIT;
            end
            ST_SCAN_WAIT: begin
               got1_ff <= got1_ff || sts1.done;
               got2_ff <= got2_ff || sts2.done;
               if (both_done) begin
                  if (sts1.found && sts2.found) begin
                     core_ff.rd_sel <= RD_CUR;
                     state_ff       <= ST_D1;
                  end else begin
                     if (sts1.found) begin
                        core_ff.upd <= UPD_C1;
                     end else if (sts2.found) begin
                        core_ff.upd <= UPD_C2;
                     end else begin
                        core_ff.upd <= UPD_KEEP;
                     end
                     core_ff.last <= last_step;
                     step_ff      <= step_ff + 1'b1;
                     state_ff     <= last_step ? ST_IDLE : ST_SCAN_GO;
                  end
               end
            end
            ST_D1: begin
               core_ff.rd_sel  <= RD_C1;
               core_ff.lat_cur <= 1'b1;
               state_ff        <= ST_D2;
            end
            ST_D2: begin
               core_ff.rd_sel <= RD_C2;
               core_ff.diff   <= 1'b1;
               state_ff       <= ST_D3;
            end
            ST_D3: begin
               core_ff.diff   <= 1'b1;
               core_ff.square <= 1'b1;
               state_ff       <= ST_D4;
            end
            ST_D4: begin
               core_ff.sum1   <= 1'b1;
               core_ff.square <= 1'b1;
               state_ff       <= ST_D5;
            end
            ST_D5: begin
               core_ff.sum2 <= 1'b1;
               state_ff     <= ST_D6;
            end
            ST_D6: begin
               core_ff.upd  <= UPD_NEAR;
               core_ff.last <= last_step;
               step_ff      <= step_ff + 1'b1;
               state_ff     <= last_step ? ST_IDLE : ST_SCAN_GO;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign scan1_cmd = scan1_ff;
   assign scan2_cmd = scan2_ff;
   assign core_cmd  = core_ff;

endmodule

[design/greedy_tour_crossover.sv]
// Top level of the greedy tour crossover block.
// Depends on gtc_pkg, gtc_ctrl, gtc_scan and gtc_core.
//
// Usage: an item is taken at a rising edge with start high and busy low.
// Opcode load coordinate writes one city's x and y, opcode load genes writes
// both parents' cities at one tour position; both finish in the accepting
// cycle and keep busy low, so loads can stream one per cycle while no run
// is in progress. Loads with a position beyond the city count and the unused
// opcode do nothing. A run item raises busy and produces NUM_CITIES results
// on rsp_data, each shown for exactly one cycle with rsp_strobe high; the
// final one has last set. The first result is the head of parent one's tour.
// Each later result costs one search of both parent tours, run side by side
// in the two tour memories, plus squared-distance work when both parents
// offer a candidate. Busy falls in the cycle before the final result shows;
// a new item can be taken then. The receiver cannot hold results off, and
// none is needed. Reset idles the controller and clears the visited map and
// current city; the coordinate and tour memories keep their contents until
// written.
module greedy_tour_crossover #(
   parameter int NUM_CITIES = gtc_pkg::NUM_CITIES_DEF,
   parameter int COORD_BITS = gtc_pkg::COORD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gtc_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output gtc_pkg::rsp_type  rsp_data
);
   import gtc_pkg::*;

   load_type              load;
   scan_cmd_type          scan1_cmd, scan2_cmd;
   core_cmd_type          core_cmd;
   scan_sts_type          sts1, sts2;
   logic [CITY_W-1:0]     cur_city;
   logic [NUM_CITIES-1:0] visited;

   gtc_ctrl #(
      .NUM_CITIES(NUM_CITIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .opcode    (req_data.opcode),
      .sts1      (sts1),
      .sts2      (sts2),
      .busy      (busy),
      .load      (load),
      .scan1_cmd (scan1_cmd),
      .scan2_cmd (scan2_cmd),
      .core_cmd  (core_cmd)
   );

   gtc_scan #(
      .NUM_CITIES(NUM_CITIES)
   ) u_scan1 (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (load.gene_we),
      .wr_pos   (req_data.position),
      .wr_city  (req_data.first_parent_city),
      .cmd      (scan1_cmd),
      .cur_city (cur_city),
      .visited  (visited),
      .sts      (sts1)
   );

   gtc_scan #(
      .NUM_CITIES(NUM_CITIES)
   ) u_scan2 (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (load.gene_we),
      .wr_pos   (req_data.position),
      .wr_city  (req_data.second_parent_city),
      .cmd      (scan2_cmd),
      .cur_city (cur_city),
      .visited  (visited),
      .sts      (sts2)
   );

   gtc_core #(
      .NUM_CITIES(NUM_CITIES),
      .COORD_BITS(COORD_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .coord_we   (load.coord_we),
      .req        (req_data),
      .cmd        (core_cmd),
      .sts1       (sts1),
      .sts2       (sts2),
      .cur_city   (cur_city),
      .visited    (visited),
      .rsp        (rsp_data),
      .rsp_strobe (rsp_strobe)
   );

endmodule

[tb/sv/greedy_tour_crossover_tb.sv]
// Self-checking testbench for greedy_tour_crossover: loads cities and parent tours,
// runs crossovers and compares every offspring city with a built-in predictor.
// Depends on gtc_pkg and the greedy_tour_crossover top level only.
`timescale 1ns / 1ps

module greedy_tour_crossover_tb;
   import gtc_pkg::*;

   localparam int CITIES = NUM_CITIES_DEF;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // Cycle budget for the whole test; it leaves ample room for every run.
   localparam int CYCLE_LIMIT = 2000000;

   class offspring_predictor;
      logic signed [IN_COORD_W-1:0] city_x [CITIES];
      logic signed [IN_COORD_W-1:0] city_y [CITIES];
      logic [CITY_W-1:0] tour [2][CITIES];
      bit visited [CITIES];
      logic [CITY_W-1:0] current_city;
      rsp_type expected_cities [$];
      int fails;

      function new();
         fails = 0;
         current_city = '0;
         foreach (visited[i]) visited[i] = 1'b0;
      endfunction

      function int pending();
         return expected_cities.size();
      endfunction

      function bit is_visited(logic [CITY_W-1:0] c);
         if (c >= CITIES) return 1'b0;
         return visited[c];
      endfunction

      function void mark(logic [CITY_W-1:0] c);
         if (c < CITIES) visited[c] = 1'b1;
      endfunction

      function longint coord(logic [CITY_W-1:0] c, bit y_axis);
         if (c >= CITIES) return 0;
         return y_axis ? longint'(city_y[c]) : longint'(city_x[c]);
      endfunction

      function longint sq_dist(logic [CITY_W-1:0] a, logic [CITY_W-1:0] b);
         longint dx;
         longint dy;
         dx = coord(a, 1'b0) - coord(b, 1'b0);
         dy = coord(a, 1'b1) - coord(b, 1'b1);
         return dx * dx + dy * dy;
      endfunction

      // Locate cur in one parent, then walk forward cyclically to the first
      // unvisited city. A parent lacking cur is walked from its head.
      function bit next_free(int which, logic [CITY_W-1:0] cur,
                             output logic [CITY_W-1:0] city);
         int p;
         int from;
         int q;
         int k;
         p = 0;
         while (p < CITIES && tour[which][p] != cur) p++;
         from = (p >= CITIES - 1) ? 0 : p + 1;
         city = cur;
         for (k = 0; k < CITIES; k++) begin
            q = (from + k) % CITIES;
            if (!is_visited(tour[which][q])) begin
               city = tour[which][q];
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void push_city(logic [CITY_W-1:0] city, bit last);
         rsp_type e;
         e.offspring_city = city;
         e.complement_city = CITY_W'(CITIES - 1 - int'(city));
         e.last = last;
         expected_cities.push_back(e);
      endfunction

      function void predict_tour();
         logic [CITY_W-1:0] cur;
         logic [CITY_W-1:0] c1;
         logic [CITY_W-1:0] c2;
         bit f1;
         bit f2;
         int j;
         foreach (visited[i]) visited[i] = 1'b0;
         cur = tour[0][0];
         mark(cur);
         push_city(cur, CITIES == 1);
         for (j = 1; j < CITIES; j++) begin
            f1 = next_free(0, cur, c1);
            f2 = next_free(1, cur, c2);
            // A tie in distance goes to the second parent.
            if (f1 && f2) begin
               cur = (sq_dist(cur, c1) < sq_dist(cur, c2)) ? c1 : c2;
               mark(cur);
            end else if (f1) begin
               cur = c1;
               mark(cur);
            end else if (f2) begin
               cur = c2;
               mark(cur);
            end
            push_city(cur, j == CITIES - 1);
         end
         current_city = cur;
      endfunction

      function void note_item(req_type r);
         case (r.opcode)
            OP_LOAD_COORD: begin
               if (r.position < CITIES) begin
                  city_x[r.position] = r.coord_x;
                  city_y[r.position] = r.coord_y;
               end
            end
            OP_LOAD_GENES: begin
               if (r.position < CITIES) begin
                  tour[0][r.position] = r.first_parent_city;
                  tour[1][r.position] = r.second_parent_city;
               end
            end
            OP_RUN: begin
               predict_tour();
            end
            default: begin
            end
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (expected_cities.size() == 0) begin
            $error("unexpected result: offspring_city %0d", got.offspring_city);
            fails++;
            return;
         end
         e = expected_cities.pop_front();
         if (got.offspring_city !== e.offspring_city) begin
            $error("offspring_city: expected %0d, actual %0d", e.offspring_city,
                   got.offspring_city);
            fails++;
         end
         if (got.complement_city !== e.complement_city) begin
            $error("complement_city: expected %0d, actual %0d", e.complement_city,
                   got.complement_city);
            fails++;
         end
         if (got.last !== e.last) begin
            $error("last: expected %0d, actual %0d", e.last, got.last);
            fails++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_strobe;
   rsp_type rsp_data;

   offspring_predictor offspring = new();
   int cycle_count = 0;
   int useful_items = 0;
   bit no_idle = 1'b0;
   logic [CITY_W-1:0] parent_a [CITIES];
   logic [CITY_W-1:0] parent_b [CITIES];

   greedy_tour_crossover i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) offspring.check_result(rsp_data);
   end

   function automatic req_type random_item();
      req_type r;
      r.opcode = 2'($urandom);
      r.position = POS_W'($urandom);
      r.coord_x = IN_COORD_W'($urandom);
      r.coord_y = IN_COORD_W'($urandom);
      r.first_parent_city = CITY_W'($urandom);
      r.second_parent_city = CITY_W'($urandom);
      return r;
   endfunction

   function automatic logic signed [IN_COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return IN_COORD_W'($urandom);
         1: return IN_COORD_W'($urandom_range(0, 3));
         2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: return IN_COORD_W'($urandom_range(0, 200)) - 16'sd100;
      endcase
   endfunction

   function automatic int gap_len();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // An item the block drops: the unused opcode or a load past the last city.
   function automatic req_type ignored_item();
      req_type r;
      r = random_item();
      if ($urandom_range(0, 1)) begin
         r.opcode = OP_UNUSED;
      end else begin
         r.opcode = $urandom_range(0, 1) ? OP_LOAD_COORD : OP_LOAD_GENES;
         r.position = POS_W'($urandom_range(CITIES, 63));
      end
      return r;
   endfunction

   // Start stays high when the next item follows at once, so it is never
   // lowered and raised within one step.
   task automatic pause(int n);
      if (n > 0) begin
         start <= 1'b0;
         req_data <= random_item();
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send(req_type item);
      req_data <= item;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      offspring.note_item(item);
      if (item.opcode == OP_RUN ||
          (item.opcode != OP_UNUSED && item.position < CITIES)) useful_items++;
      pause(gap_len());
   endtask

   task automatic wait_results();
      if (offspring.pending() != 0) begin
         start <= 1'b0;
         while (offspring.pending() != 0) @(posedge clock);
      end
   endtask

   task automatic load_coord(int city, logic signed [IN_COORD_W-1:0] x,
                             logic signed [IN_COORD_W-1:0] y);
      req_type r;
      r = random_item();
      r.opcode = OP_LOAD_COORD;
      r.position = POS_W'(city);
      r.coord_x = x;
      r.coord_y = y;
      send(r);
   endtask

   task automatic load_genes(int pos, logic [CITY_W-1:0] g1, logic [CITY_W-1:0] g2);
      req_type r;
      r = random_item();
      r.opcode = OP_LOAD_GENES;
      r.position = POS_W'(pos);
      r.first_parent_city = g1;
      r.second_parent_city = g2;
      send(r);
   endtask

   task automatic run_crossover();
      req_type r;
      r = random_item();
      r.opcode = OP_RUN;
      send(r);
   endtask

   task automatic restore_genes(int pos);
      load_genes(pos, parent_a[pos], parent_b[pos]);
   endtask

   task automatic swap_genes();
      int i;
      int j;
      logic [CITY_W-1:0] t;
      i = $urandom_range(0, CITIES - 1);
      j = $urandom_range(0, CITIES - 1);
      if ($urandom_range(0, 1)) begin
         t = parent_a[i];
         parent_a[i] = parent_a[j];
         parent_a[j] = t;
      end else begin
         t = parent_b[i];
         parent_b[i] = parent_b[j];
         parent_b[j] = t;
      end
      restore_genes(i);
      restore_genes(j);
   endtask

   task automatic shuffle_parents();
      int i;
      int j;
      logic [CITY_W-1:0] t;
      for (i = 0; i < CITIES; i++) begin
         parent_a[i] = CITY_W'(i);
         parent_b[i] = CITY_W'(i);
      end
      for (i = CITIES - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = parent_a[i];
         parent_a[i] = parent_a[j];
         parent_a[j] = t;
         j = $urandom_range(0, i);
         t = parent_b[i];
         parent_b[i] = parent_b[j];
         parent_b[j] = t;
      end
   endtask

   function automatic int find_in_b(logic [CITY_W-1:0] city);
      int p;
      for (p = 0; p < CITIES; p++) begin
         if (parent_b[p] == city) return p;
      end
      return 0;
   endfunction

   initial begin
      int i;
      int n;
      int p;
      int q;
      int kind;
      int spots [3];
      logic [CITY_W-1:0] a;
      logic [CITY_W-1:0] b;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Every coordinate and tour entry is written before the first run.
      shuffle_parents();
      for (i = 0; i < CITIES; i++) load_coord(i, rand_coord(), rand_coord());
      for (i = 0; i < CITIES; i++) restore_genes(i);

      // Coordinate extremes, ignored items, then a plain run.
      load_coord(0, 16'sh8000, 16'sh8000);
      load_coord(1, 16'sh7fff, 16'sh7fff);
      load_coord(63, 16'sh7fff, 16'sh8000);
      load_genes(CITIES, 6'd63, 6'd63);
      send(ignored_item());
      run_crossover();

      // Make the two first candidates equally far away, forcing a tie.
      a = parent_a[1];
      p = find_in_b(parent_a[0]);
      b = parent_b[(p + 1) % CITIES];
      if (a != b) load_coord(b, offspring.city_x[a], offspring.city_y[a]);
      run_crossover();

      // Broken tours: an out-of-range head, a city absent from both parents
      // and a duplicate, so that parents run dry near the end of the tour.
      q = find_in_b(parent_a[5]);
      load_genes(0, 6'd63, parent_b[0]);
      load_genes(5, 6'd62, (q == 5) ? 6'd62 : parent_b[5]);
      if (q != 5) load_genes(q, parent_a[q], 6'd62);
      load_genes(9, parent_a[9], 6'd0);
      run_crossover();
      restore_genes(0);
      restore_genes(5);
      restore_genes(q);
      restore_genes(9);
      wait_results();

      while (useful_items < 130) begin
         no_idle = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            repeat ($urandom_range(0, 2)) swap_genes();
            repeat ($urandom_range(0, 3)) begin
               load_coord($urandom_range(0, CITIES - 1), rand_coord(), rand_coord());
            end
            if ($urandom_range(0, 4) == 0) send(ignored_item());
            run_crossover();
         end else if (kind < 8) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) begin
               spots[i] = $urandom_range(0, CITIES - 1);
               load_genes(spots[i],
                          $urandom_range(0, 1) ? CITY_W'($urandom) :
                                                 CITY_W'($urandom_range(0, CITIES - 1)),
                          $urandom_range(0, 1) ? CITY_W'($urandom) :
                                                 CITY_W'($urandom_range(0, CITIES - 1)));
            end
            run_crossover();
            for (i = 0; i < n; i++) restore_genes(spots[i]);
         end else if (kind == 8) begin
            send(ignored_item());
            run_crossover();
            run_crossover();
         end else begin
            wait_results();
            run_crossover();
         end
      end

      wait_results();
      repeat (50) @(posedge clock);
      if (offspring.fails == 0 && offspring.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
